[sv/cdau_pkg.sv]
package cdau_pkg;

    typedef enum logic [2:0] {
        FN_TO_SERIAL  = 3'd0,
        FN_TO_DATE    = 3'd1,
        FN_ADD_DAYS   = 3'd2,
        FN_ADD_MONTHS = 3'd3,
        FN_ADD_YEARS  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MONTH = 3'd1,
        ST_BAD_DAY   = 3'd2,
        ST_RANGE     = 3'd3,
        ST_BAD_FUNC  = 3'd4
    } status_t;

    localparam int unsigned NUM_STAGES   = 16;
    localparam int unsigned CIVIL_STAGES = 8;

    // operands carried alongside the serial-to-date stages
    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [5:0]         day;
        logic signed [24:0] amount;
        logic               over;
    } side_t;

    // working date in the back half of the pipeline
    typedef struct packed {
        logic [2:0]         op;
        status_t            st;
        logic signed [25:0] yr;
        logic [3:0]         mon;
        logic [5:0]         day;
    } date_t;

    // days from march 1 to the first of the shifted month (march = 0)
    function automatic logic [8:0] mar_off(input logic [3:0] sm);
        logic [8:0] r;
        case (sm)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] month_to_sm(input logic [3:0] m);
        return (m > 4'd2) ? 4'(m - 4'd3) : 4'(m + 4'd9);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:    r = leap ? 5'd29 : 5'd28;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // yoe / 100 for a year of era below 400
    function automatic logic [1:0] cent_count(input logic [8:0] yoe);
        return 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
    endfunction

endpackage

[sv/civil_date_arithmetic_unit_top.sv]
// channel  dir  tdata (low bit up)                                tuser
// s_       in   serial_in 25, year_in 16, month_in 4, day_in 6,   func 3
//               amount 25, pad 4
// m_       out  serial_out 25, year_out 16, month_out 4,          status 3
//               day_out 5, weekday 3, pad 3
//
// 16-stage pipeline, one item per cycle when not stalled.
// Stages 0-7 turn a serial into a date, 8-11 pick and range-check the target
// year, 12-15 turn the target date back into a serial and weekday.
// aresetn clears only the stage valid bits.
// Each stage holds while it and the stages after it are full and m_tready is low,
// so empty stages keep filling while a result waits at the output.
module civil_date_arithmetic_unit_top
    import cdau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // serial_in, year_in, month_in, day_in, amount
    input  logic [2:0]  s_tuser,  // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // serial_out, year_out, month_out, day_out, weekday
    output logic [2:0]  m_tuser   // status
);

    localparam logic [26:0] M_12  = 27'(((64'd1 << 30) + 64'd11) / 64'd12);
    localparam logic [17:0] M_400 = 18'(((64'd1 << 26) + 64'd399) / 64'd400);
    localparam logic [18:0] M_7   = 19'(((64'd1 << 21) + 64'd6) / 64'd7);

    logic [NUM_STAGES-1:0] v_reg, v_next, en;

    // ---- input decode
    logic [2:0]         in_func;
    logic signed [24:0] in_serial, in_amount;
    logic signed [25:0] day_sum, src;
    side_t              side_next;
    side_t              side_reg [CIVIL_STAGES];

    assign in_func   = s_tuser;
    assign in_serial = s_tdata[24:0];
    assign in_amount = s_tdata[75:51];
    assign day_sum   = 26'(in_serial) + 26'(in_amount);
    assign src       = (in_func == FN_ADD_DAYS) ? day_sum : 26'(in_serial);

    always_comb begin
        side_next.op     = in_func;
        side_next.year   = s_tdata[40:25];
        side_next.month  = s_tdata[44:41];
        side_next.day    = s_tdata[50:45];
        side_next.amount = in_amount;
        side_next.over   = (in_func == FN_ADD_DAYS) && (day_sum[25] != day_sum[24]);
    end

    // ---- handshake: a stage moves when it or any later stage has room, or m_tready is high
    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            en[k] = m_tready
                 || ((v_reg | NUM_STAGES'((32'd1 << k) - 32'd1)) != '1);
            if (k == 0) begin
                v_next[k] = en[k] ? s_tvalid : v_reg[k];
            end else begin
                v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];

    // ---- serial to date
    logic signed [17:0] civ_year;
    logic [3:0]         civ_month;
    logic [4:0]         civ_day;

    cdau_civil u_civil (
        .aclk    (aclk),
        .en      (en[CIVIL_STAGES-1:0]),
        .src     (src),
        .year_o  (civ_year),
        .month_o (civ_month),
        .day_o   (civ_day)
    );

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            side_reg[0] <= side_next;
        end
        for (int k = 1; k < CIVIL_STAGES; k++) begin
            if (en[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---- stage 8: choose the working date
    side_t       sd;
    date_t       dt8_next, dt8_reg;
    logic [25:0] total8_next, total8_reg;

    assign sd = side_reg[CIVIL_STAGES-1];
    // months since year 0 plus 12 * 2^21 so the split by 12 sees a positive value
    assign total8_next = 26'(27'(civ_year) * 27'd12 + 27'(civ_month) - 27'd1
                       + 27'(sd.amount) + 27'd25165824);

    always_comb begin
        dt8_next.op  = sd.op;
        dt8_next.mon = civ_month;
        dt8_next.day = 6'(civ_day);
        dt8_next.yr  = 26'(civ_year);
        if (sd.op == FN_TO_SERIAL) begin
            dt8_next.yr  = 26'(sd.year);
            dt8_next.mon = sd.month;
            dt8_next.day = sd.day;
        end else if (sd.op == FN_ADD_YEARS) begin
            dt8_next.yr = 26'(civ_year) + 26'(sd.amount);
        end
        if (sd.op > FN_ADD_YEARS) begin
            dt8_next.st = ST_BAD_FUNC;
        end else if (sd.op == FN_TO_SERIAL && (sd.month == 4'd0 || sd.month > 4'd12)) begin
            dt8_next.st = ST_BAD_MONTH;
        end else if (sd.over) begin
            dt8_next.st = ST_RANGE;
        end else begin
            dt8_next.st = ST_OK;
        end
    end

    // ---- stage 9: months split into years
    logic [52:0] prod12;
    logic [21:0] q9_reg;
    logic [25:0] total9_reg;
    date_t       dt9_reg;

    assign prod12 = 53'(total8_reg) * 53'(M_12);

    // ---- stage 10: target year, range check
    date_t       dt10_next, dt10_reg;
    logic [16:0] uy10_next, up10_next, uy10_reg, up10_reg;

    always_comb begin
        dt10_next = dt9_reg;
        if (dt9_reg.op == FN_ADD_MONTHS) begin
            dt10_next.yr  = $signed(26'(q9_reg)) - 26'sd2097152;
            dt10_next.mon = 4'(total9_reg - 26'(q9_reg) * 26'd12) + 4'd1;
        end
        if (dt9_reg.st == ST_OK
            && ($signed(dt10_next.yr) < -26'sd32768 || $signed(dt10_next.yr) > 26'sd32767)) begin
            dt10_next.st = ST_RANGE;
        end
        // year plus 82 eras; the second copy counts from march
        uy10_next = 17'($signed(dt10_next.yr[15:0])) + 17'd32800;
        up10_next = uy10_next - 17'(dt10_next.mon <= 4'd2);
    end

    // ---- stage 11: split both years by 400
    logic [34:0] prod_y, prod_p;
    logic [7:0]  qy11_reg, qp11_reg;
    logic [16:0] uy11_reg, up11_reg;
    date_t       dt11_reg;

    assign prod_y = 35'(uy10_reg) * 35'(M_400);
    assign prod_p = 35'(up10_reg) * 35'(M_400);

    // ---- stage 12: leap year, day check and clamp, day of year
    logic [8:0]        ry, yoe12_next, yoe12_reg, doy12_next, doy12_reg;
    logic              leap;
    logic [4:0]        lim, dclamp;
    logic signed [8:0] era12_next, era12_reg;
    date_t             dt12_next, dt12_reg;

    always_comb begin
        ry         = 9'(uy11_reg - 17'(qy11_reg) * 17'd400);
        leap       = (ry[1:0] == 2'd0) && ry != 9'd100 && ry != 9'd200 && ry != 9'd300;
        lim        = month_days(dt11_reg.mon, leap);
        dt12_next  = dt11_reg;
        if (dt11_reg.st == ST_OK && dt11_reg.op == FN_TO_SERIAL
            && (dt11_reg.day == 6'd0 || dt11_reg.day > 6'(lim))) begin
            dt12_next.st = ST_BAD_DAY;
        end
        dclamp        = (dt11_reg.day > 6'(lim)) ? lim : dt11_reg.day[4:0];
        dt12_next.day = 6'(dclamp);
        yoe12_next    = 9'(up11_reg - 17'(qp11_reg) * 17'd400);
        era12_next    = $signed(9'(qp11_reg)) - 9'sd82;
        doy12_next    = 9'(mar_off(month_to_sm(dt11_reg.mon)) + 9'(dclamp) - 9'd1);
    end

    // ---- stage 13: day of era
    logic [17:0]       doe13_next, doe13_reg;
    logic signed [8:0] era13_reg;
    date_t             dt13_reg;

    assign doe13_next = 18'(yoe12_reg) * 18'd365 + 18'(yoe12_reg >> 2)
                      - 18'(cent_count(yoe12_reg)) + 18'(doy12_reg);

    // ---- stage 14: serial, weekday quotient
    logic [24:0] ser14_next, ser14_reg;
    logic [17:0] w14_next, w14_reg;
    logic [36:0] prod7;
    logic [14:0] q14_reg;
    date_t       dt14_reg;

    assign ser14_next = 25'(27'(era13_reg) * 27'd146097 + 27'(doe13_reg) - 27'd719468);
    // eras are whole weeks, so the weekday follows from the day of era alone
    assign w14_next   = doe13_reg + 18'd2;
    assign prod7      = 37'(w14_next) * 37'(M_7);

    // ---- stage 15: output register
    logic [2:0]  wd;
    logic [55:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg;

    always_comb begin
        wd = 3'(w14_reg - 18'(q14_reg) * 18'd7);
        if (dt14_reg.st == ST_OK) begin
            m_tdata_next = {3'd0, wd, dt14_reg.day[4:0], dt14_reg.mon,
                            dt14_reg.yr[15:0], ser14_reg};
        end else begin
            m_tdata_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            dt8_reg    <= dt8_next;
            total8_reg <= total8_next;
        end
        if (en[9]) begin
            dt9_reg    <= dt8_reg;
            total9_reg <= total8_reg;
            q9_reg     <= prod12[51:30];
        end
        if (en[10]) begin
            dt10_reg <= dt10_next;
            uy10_reg <= uy10_next;
            up10_reg <= up10_next;
        end
        if (en[11]) begin
            dt11_reg <= dt10_reg;
            uy11_reg <= uy10_reg;
            up11_reg <= up10_reg;
            qy11_reg <= prod_y[33:26];
            qp11_reg <= prod_p[33:26];
        end
        if (en[12]) begin
            dt12_reg  <= dt12_next;
            yoe12_reg <= yoe12_next;
            era12_reg <= era12_next;
            doy12_reg <= doy12_next;
        end
        if (en[13]) begin
            dt13_reg  <= dt12_reg;
            era13_reg <= era12_reg;
            doe13_reg <= doe13_next;
        end
        if (en[14]) begin
            dt14_reg  <= dt13_reg;
            ser14_reg <= ser14_next;
            w14_reg   <= w14_next;
            q14_reg   <= prod7[35:21];
        end
        if (en[15]) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= dt14_reg.st;
        end
    end

    assign m_tvalid = v_reg[NUM_STAGES-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---- checks
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("error item carries nonzero fields");

    a_ok_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_OK) |->
            (m_tdata[44:41] >= 4'd1) && (m_tdata[44:41] <= 4'd12)
            && (m_tdata[49:45] != 5'd0) && (m_tdata[52:50] <= 3'd6))
        else $error("ok item with impossible date or weekday");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted item not held in first stage");

endmodule

[sv/cdau_civil.sv]
module cdau_civil
    import cdau_pkg::*;
(
    input  logic                    aclk,
    input  logic [CIVIL_STAGES-1:0] en,
    input  logic signed [25:0]      src,
    output logic signed [17:0]      year_o,
    output logic [3:0]              month_o,
    output logic [4:0]              day_o
);

    localparam logic [26:0] T_OFS  = 27'd35198360;
    localparam logic [27:0] M_ERA  = 28'(((64'd1 << 45) + 64'd146096) / 64'd146097);
    localparam logic [18:0] M_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);

    logic [26:0]        t_reg, t1_reg;
    logic [8:0]         era1_reg, era2_reg, era3_reg, era4_reg, era5_reg, era6_reg;
    logic [17:0]        doe2_reg, doe3_reg, doe4_reg, doe5_reg;
    logic [6:0]         q3_reg;
    logic [17:0]        n4_reg;
    logic [8:0]         yoe5_reg, yoe6_reg;
    logic [8:0]         doy6_reg;
    logic signed [17:0] year_reg;
    logic [3:0]         month_reg;
    logic [4:0]         day_reg;

    logic [26:0]        t_next;
    logic [54:0]        prod_era;
    logic [17:0]        doe2_next;
    logic [36:0]        prod_1460;
    logic [2:0]         quad_cent;
    logic [17:0]        n4_next;
    logic [36:0]        prod_365;
    logic [8:0]         doy6_next;
    logic [3:0]         sm;
    logic [3:0]         mm;
    logic [4:0]         day_next;
    logic signed [17:0] year_next;

    // add the march-epoch offset and whole eras so the floor division works on a positive value
    assign t_next    = 27'(src) + T_OFS;
    assign prod_era  = 55'(t_reg) * 55'(M_ERA);
    assign doe2_next = 18'(t1_reg - 27'(era1_reg) * 27'd146097);
    assign prod_1460 = 37'(doe2_reg) * 37'(M_1460);
    assign quad_cent = 3'(doe3_reg >= 18'd36524) + 3'(doe3_reg >= 18'd73048)
                     + 3'(doe3_reg >= 18'd109572) + 3'(doe3_reg >= 18'd146096);
    assign n4_next   = 18'(doe3_reg - 18'(q3_reg) + 18'(quad_cent)
                     - 18'(doe3_reg == 18'd146096));
    assign prod_365  = 37'(n4_reg) * 37'(M_365);
    assign doy6_next = 9'(doe5_reg - (18'(yoe5_reg) * 18'd365 + 18'(yoe5_reg >> 2)
                     - 18'(cent_count(yoe5_reg))));

    always_comb begin
        sm = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (doy6_reg >= mar_off(4'(k))) begin
                sm = 4'(k);
            end
        end
        day_next  = 5'(doy6_reg - mar_off(sm) + 9'd1);
        mm        = (sm < 4'd10) ? 4'(sm + 4'd3) : 4'(sm - 4'd9);
        // era offset of 236 removed here, january and february belong to the next year
        year_next = 18'(19'(yoe6_reg) + 19'(era6_reg) * 19'd400 - 19'd94400
                  + 19'(mm <= 4'd2));
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t_reg <= t_next;
        end
        if (en[1]) begin
            era1_reg <= prod_era[53:45];
            t1_reg   <= t_reg;
        end
        if (en[2]) begin
            era2_reg <= era1_reg;
            doe2_reg <= doe2_next;
        end
        if (en[3]) begin
            era3_reg <= era2_reg;
            doe3_reg <= doe2_reg;
            q3_reg   <= prod_1460[35:29];
        end
        if (en[4]) begin
            era4_reg <= era3_reg;
            doe4_reg <= doe3_reg;
            n4_reg   <= n4_next;
        end
        if (en[5]) begin
            era5_reg <= era4_reg;
            doe5_reg <= doe4_reg;
            yoe5_reg <= prod_365[35:27];
        end
        if (en[6]) begin
            era6_reg <= era5_reg;
            yoe6_reg <= yoe5_reg;
            doy6_reg <= doy6_next;
        end
        if (en[7]) begin
            year_reg  <= year_next;
            month_reg <= mm;
            day_reg   <= day_next;
        end
    end

    assign year_o  = year_reg;
    assign month_o = month_reg;
    assign day_o   = day_reg;

endmodule
